[rtl/qrvu_pkg.sv]
package qrvu_pkg;

   localparam int ROT_FRAC_BITS_DEF = 28;
   localparam int CORDIC_STEPS_DEF  = 24;

   localparam int ISQ_STEPS = 32;   // bit pairs of the 64-bit squared magnitude
   localparam int DIV_STEPS = 32;   // quotient bits of sin*r/m
   localparam int ANG_W     = 35;   // angle and CORDIC datapath width

   localparam logic [63:0] ANG_TWO_PI   = 64'd6746518852;
   localparam logic signed [ANG_W-1:0] ANG_PI      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;
   localparam logic signed [ANG_W-1:0] CORDIC_K    = 35'sd652032874;

   typedef struct packed {
      logic              func;
      logic signed [31:0] q_w;
      logic signed [31:0] q_x;
      logic signed [31:0] q_y;
      logic signed [31:0] q_z;
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_w;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic              saturated;
   } rsp_type;

   // side data that rides along the pipe; later fields fill in as they are known
   typedef struct packed {
      logic              func;
      logic              zero;
      logic [3:0][31:0]  q;
      logic [2:0][31:0]  r;
      logic [31:0]       m;
      logic              neg;
      logic [31:0]       c;
      logic [2:0]        sgn;
   } carry_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = 35'sd843314856;
         5'd1:  v = 35'sd497837829;
         5'd2:  v = 35'sd263043836;
         5'd3:  v = 35'sd133525158;
         5'd4:  v = 35'sd66987894;
         5'd5:  v = 35'sd33544539;
         5'd6:  v = 35'sd16776874;
         5'd7:  v = 35'sd8388437;
         5'd8:  v = 35'sd4194282;
         5'd9:  v = 35'sd2097149;
         5'd10: v = 35'sd1048575;
         5'd11: v = 35'sd524287;
         5'd12: v = 35'sd262143;
         5'd13: v = 35'sd131071;
         5'd14: v = 35'sd65535;
         5'd15: v = 35'sd32767;
         5'd16: v = 35'sd16383;
         5'd17: v = 35'sd8191;
         5'd18: v = 35'sd4095;
         5'd19: v = 35'sd2047;
         5'd20: v = 35'sd1023;
         5'd21: v = 35'sd511;
         5'd22: v = 35'sd255;
         5'd23: v = 35'sd127;
         5'd24: v = 35'sd63;
         5'd25: v = 35'sd31;
         5'd26: v = 35'sd15;
         5'd27: v = 35'sd8;
         5'd28: v = 35'sd4;
         5'd29: v = 35'sd2;
         5'd30: v = 35'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/quaternion_rotation_vector_update_core.sv]
// Quaternion update from a rotation vector. Each beat carries an attitude
// quaternion q (Q2.30) and a rotation vector r (radians, ROT_FRAC_BITS
// fraction bits); the result beat is q*p (func 0, propagation) or p*q
// (func 1, tilt correction) with p = [cos(|r|/2), sin(|r|/2)/|r| * r],
// rounded and saturated to Q2.30, with a flag when any part clipped. A zero
// vector returns q as is. Fully pipelined: one beat per clock in and out
// while the pipe is not held. Most of the pipe is the 32-stage square
// root, the angle reduction stages,
// one stage per CORDIC step and the 32-stage divider for sin*r/|r|. The
// whole pipe holds when the output stage is full and rsp_ready is low, so
// req_ready follows rsp_ready in that case. No state between beats.
module quaternion_rotation_vector_update_core
   import qrvu_pkg::*;
#(
   parameter int ROT_FRAC_BITS = ROT_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SH  = 30 - ROT_FRAC_BITS;      // rotation format to Q30
   localparam int HW  = 32 + SH;                  // half-angle width
   localparam int RED = (HW > 32) ? HW - 32 : 1;  // mod 2pi subtract steps

   // stage positions
   localparam int P_SQ   = 0;
   localparam int P_SUM  = 1;
   localparam int P_ISQ  = 2;
   localparam int P_H    = P_ISQ + ISQ_STEPS;
   localparam int P_RED  = P_H + 1;
   localparam int P_FOLD = P_RED + RED;
   localparam int P_COR  = P_FOLD + 1;
   localparam int P_MUL  = P_COR + CORDIC_STEPS;
   localparam int P_HP   = P_MUL + DIV_STEPS + 1;
   localparam int P_HS   = P_HP + 1;
   localparam int P_OUT  = P_HS + 1;
   localparam int NST    = P_OUT + 1;

   logic           en;
   logic [NST-1:0] vld_ff;
   carry_type      car_ff [NST];
   carry_type      car_in [NST];

   logic [63:0] sq_ff [3];
   logic [63:0] sq_in [3];
   logic [63:0] sum_ff, sum_in;
   logic [63:0] isn_ff [ISQ_STEPS];
   logic [63:0] isn_in [ISQ_STEPS];
   logic [63:0] isr_ff [ISQ_STEPS];
   logic [63:0] isr_in [ISQ_STEPS];
   logic [31:0] mv;
   logic [HW-1:0] h_ff, h_in;
   logic [HW-1:0] red_ff [RED];
   logic [HW-1:0] red_in [RED];
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic        neg_c;
   logic signed [ANG_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] x_in [CORDIC_STEPS];
   logic signed [ANG_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] y_in [CORDIC_STEPS];
   logic signed [ANG_W-1:0] z_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] z_in [CORDIC_STEPS];
   logic [31:0] c_c;
   logic [2:0]  sgn_c;
   logic [32:0] drem_ff [DIV_STEPS+1][3];
   logic [32:0] drem_in [DIV_STEPS+1][3];
   logic [31:0] dlo_ff  [DIV_STEPS+1][3];
   logic [31:0] dlo_in  [DIV_STEPS+1][3];
   logic [31:0] dq_ff   [DIV_STEPS+1][3];
   logic [31:0] dq_in   [DIV_STEPS+1][3];
   logic signed [63:0] prd_ff [4][4];
   logic signed [63:0] prd_in [4][4];
   logic signed [65:0] o_ff [4];
   logic signed [65:0] o_in [4];
   rsp_type     rsp_ff, rsp_in;

   // global hold: advance unless the output beat is stuck
   assign en        = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_data  = rsp_ff;

   // side data
   always_comb begin
      car_in[0].func = req_data.func;
      car_in[0].zero = (req_data.rot_x == 0) && (req_data.rot_y == 0) &&
                       (req_data.rot_z == 0);
      car_in[0].q    = {req_data.q_z, req_data.q_y, req_data.q_x, req_data.q_w};
      car_in[0].r    = {req_data.rot_z, req_data.rot_y, req_data.rot_x};
      car_in[0].m    = '0;
      car_in[0].neg  = 1'b0;
      car_in[0].c    = '0;
      car_in[0].sgn  = '0;
      for (int i = 1; i < NST; i++) begin
         car_in[i] = car_ff[i-1];
      end
      car_in[P_H].m      = mv;
      car_in[P_FOLD].neg = neg_c;
      car_in[P_MUL].c    = c_c;
      car_in[P_MUL].sgn  = sgn_c;
   end

   // squares and their sum
   always_comb begin
      logic [31:0] ra;
      for (int i = 0; i < 3; i++) begin
         ra = req_data[32*(2-i) +: 32];
         if (ra[31]) begin
            ra = 32'(-ra);
         end
         sq_in[i] = 64'(ra) * 64'(ra);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // floor square root, one result bit per stage
   always_comb begin
      logic [63:0] np, rp, bt, t;
      for (int k = 0; k < ISQ_STEPS; k++) begin
         np = (k == 0) ? sum_ff : isn_ff[(k == 0) ? 0 : k-1];
         rp = (k == 0) ? 64'd0  : isr_ff[(k == 0) ? 0 : k-1];
         bt = 64'd1 << (62 - 2*k);
         t  = rp + bt;
         if (np >= t) begin
            isn_in[k] = np - t;
            isr_in[k] = (rp >> 1) + bt;
         end else begin
            isn_in[k] = np;
            isr_in[k] = rp >> 1;
         end
      end
   end

   // half angle in Q30, then mod 2pi by restoring subtracts
   always_comb begin
      logic [HW-1:0] hp;
      logic [63:0]   tw;
      mv = isr_ff[ISQ_STEPS-1][31:0];
      if (mv == '0) begin
         mv = 32'd1;
      end
      h_in = HW'((64'(mv) << SH) >> 1);
      for (int k = 0; k < RED; k++) begin
         hp = (k == 0) ? h_ff : red_ff[(k == 0) ? 0 : k-1];
         tw = ANG_TWO_PI << (RED - 1 - k);
         red_in[k] = (64'(hp) >= tw) ? HW'(64'(hp) - tw) : hp;
      end
   end

   // wrap to (-pi, pi], fold into [-pi/2, pi/2]
   always_comb begin
      logic signed [ANG_W-1:0] a;
      a     = $signed(ANG_W'(red_ff[RED-1]));
      neg_c = 1'b0;
      if (a > ANG_PI) begin
         a = a - $signed(ANG_W'(ANG_TWO_PI));
      end
      if (a > ANG_HALF_PI) begin
         a     = ANG_PI - a;
         neg_c = 1'b1;
      end else if (a < -ANG_HALF_PI) begin
         a     = -ANG_PI - a;
         neg_c = 1'b1;
      end
      ang_in = a;
   end

   // rotation-mode CORDIC, one step per stage
   always_comb begin
      logic signed [ANG_W-1:0] xp, yp, zp;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (k == 0) begin
            xp = CORDIC_K;
            yp = '0;
            zp = ang_ff;
         end else begin
            xp = x_ff[(k == 0) ? 0 : k-1];
            yp = y_ff[(k == 0) ? 0 : k-1];
            zp = z_ff[(k == 0) ? 0 : k-1];
         end
         if (zp >= 0) begin
            x_in[k] = xp - (yp >>> k);
            y_in[k] = yp + (xp >>> k);
            z_in[k] = zp - atan_q30(5'(k));
         end else begin
            x_in[k] = xp + (yp >>> k);
            y_in[k] = yp - (xp >>> k);
            z_in[k] = zp + atan_q30(5'(k));
         end
      end
   end

   // sin*r products, then divide magnitudes by m, one quotient bit per stage
   always_comb begin
      logic signed [ANG_W-1:0] cx;
      logic signed [31:0] s32;
      logic signed [63:0] pr;
      logic [63:0] mag;
      logic [32:0] t, m33;
      cx    = x_ff[CORDIC_STEPS-1];
      if (car_ff[P_MUL-1].neg) begin
         cx = -cx;
      end
      c_c   = 32'(cx);
      s32   = 32'(y_ff[CORDIC_STEPS-1]);
      sgn_c = '0;
      for (int i = 0; i < 3; i++) begin
         pr  = 64'(s32) * 64'($signed(car_ff[P_MUL-1].r[i]));
         sgn_c[i] = pr[63];
         mag = pr[63] ? 64'(-pr) : 64'(pr);
         drem_in[0][i] = {1'b0, mag[63:32]};
         dlo_in[0][i]  = mag[31:0];
         dq_in[0][i]   = '0;
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         m33 = {1'b0, car_ff[P_MUL+k].m};
         for (int i = 0; i < 3; i++) begin
            t = {drem_ff[k][i][31:0], dlo_ff[k][i][31]};
            dlo_in[k+1][i] = dlo_ff[k][i] << 1;
            if (t >= m33) begin
               drem_in[k+1][i] = t - m33;
               dq_in[k+1][i]   = {dq_ff[k][i][30:0], 1'b1};
            end else begin
               drem_in[k+1][i] = t;
               dq_in[k+1][i]   = {dq_ff[k][i][30:0], 1'b0};
            end
         end
      end
   end

   // Hamilton product terms
   always_comb begin
      logic signed [31:0] pq [4];
      logic signed [31:0] qq [4];
      logic signed [31:0] av [4];
      logic signed [31:0] bv [4];
      carry_type cr;
      cr = car_ff[P_HP-1];
      pq[0] = $signed(cr.c);
      for (int i = 0; i < 3; i++) begin
         pq[i+1] = cr.sgn[i] ? -$signed(dq_ff[DIV_STEPS][i])
                             :  $signed(dq_ff[DIV_STEPS][i]);
      end
      for (int i = 0; i < 4; i++) begin
         qq[i] = $signed(cr.q[i]);
         av[i] = cr.func ? pq[i] : qq[i];
         bv[i] = cr.func ? qq[i] : pq[i];
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prd_in[i][j] = 64'(av[i]) * 64'(bv[j]);
         end
      end
   end

   // term sums, each term floored by two bits first
   always_comb begin
      logic signed [65:0] t [4][4];
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            t[i][j] = 66'(prd_ff[i][j] >>> 2);
         end
      end
      o_in[0] = t[0][0] - t[1][1] - t[2][2] - t[3][3];
      o_in[1] = t[1][0] + t[0][1] - t[3][2] + t[2][3];
      o_in[2] = t[2][0] + t[3][1] + t[0][2] - t[1][3];
      o_in[3] = t[3][0] - t[2][1] + t[1][2] + t[0][3];
   end

   // round, saturate, zero-vector bypass
   always_comb begin
      logic signed [65:0] v;
      logic [3:0][31:0]   res;
      logic               sat;
      carry_type          cr;
      cr  = car_ff[P_OUT-1];
      sat = 1'b0;
      for (int i = 0; i < 4; i++) begin
         v = (o_ff[i] + 66'sd134217728) >>> 28;
         if (v > 66'sd2147483647) begin
            res[i] = 32'h7fff_ffff;
            sat    = 1'b1;
         end else if (v < -66'sd2147483648) begin
            res[i] = 32'h8000_0000;
            sat    = 1'b1;
         end else begin
            res[i] = v[31:0];
         end
      end
      if (cr.zero) begin
         res = cr.q;
         sat = 1'b0;
      end
      rsp_in.out_w     = $signed(res[0]);
      rsp_in.out_x     = $signed(res[1]);
      rsp_in.out_y     = $signed(res[2]);
      rsp_in.out_z     = $signed(res[3]);
      rsp_in.saturated = sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         car_ff <= car_in;
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
         isn_ff <= isn_in;
         isr_ff <= isr_in;
         h_ff   <= h_in;
         red_ff <= red_in;
         ang_ff <= ang_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         drem_ff <= drem_in;
         dlo_ff <= dlo_in;
         dq_ff  <= dq_in;
         prd_ff <= prd_in;
         o_ff   <= o_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule
